@@ rtl/tsbd_pkg.sv @@
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// Touch scan baseline detector package
// Shared widths, field codes and parameter defaults for the touch qualifier.
// ----------------------------------------------------------------------------
package tsbd_pkg;

   localparam int CHANNELS_DEF    = 5;
   localparam int WINDOW_SIZE_DEF = 8;

   localparam int RISE_W   = 16;
   localparam int CAL_W    = 3;
   localparam int THRESH_W = 16;

   // Packed beat widths, padded to whole bytes.
   localparam int REQ_DATA_W = 24;
   localparam int RSP_DATA_W = 8;

   localparam logic [THRESH_W-1:0] THRESHOLD_RESET = 16'd15;

   // Codes carried in req_tuser.
   localparam logic KIND_CAL  = 1'b0;
   localparam logic KIND_SCAN = 1'b1;

endpackage

@@ rtl/touch_scan_baseline_detector.sv @@
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// Touch scan baseline detector
// Multi-channel capacitive touch qualifier with a moving-average baseline.
// ----------------------------------------------------------------------------
// The block takes one beat per clock while the result side is not stalled
// and returns exactly one result beat for each: the request goes into an
// input register, the channel update and the touch decision are made in one
// pass, and the result lands in an output register.
// Each channel keeps its sample window as a shift line with a running sum and
// a registered baseline, so a window update costs one add, one subtract and
// one constant multiply for the divide by the window size. Calibration beats
// (tuser = 0) push a sample into the named channel; scan beats (tuser = 1)
// test the channel under the round-robin pointer. Channel state comes out of
// reset cleared and the threshold resets to 15, so the block is usable right
// after reset. The csr port, which is always ready, writes the threshold.
// ----------------------------------------------------------------------------
module touch_scan_baseline_detector #(
   parameter int CHANNELS    = tsbd_pkg::CHANNELS_DEF,
   parameter int WINDOW_SIZE = tsbd_pkg::WINDOW_SIZE_DEF
) (
   input  logic                            clock,
   input  logic                            reset,
   // Request: tdata = cal_channel[2:0], charge_time[18:3], zero pad; tuser = kind.
   input  logic                            req_tvalid,
   output logic                            req_tready,
   input  logic [tsbd_pkg::REQ_DATA_W-1:0] req_tdata,
   input  logic                            req_tuser,
   // Response: tdata = pressed_channel[2:0], zero pad; tuser = press_event.
   output logic                            rsp_tvalid,
   input  logic                            rsp_tready,
   output logic [tsbd_pkg::RSP_DATA_W-1:0] rsp_tdata,
   output logic                            rsp_tuser,
   // Threshold write.
   input  logic                            csr_valid,
   output logic                            csr_ready,
   input  logic [tsbd_pkg::THRESH_W-1:0]   csr_wdata
);

   import tsbd_pkg::*;

   localparam int CH_W      = (CHANNELS > 1) ? $clog2(CHANNELS) : 1;
   localparam int WIN_L     = $clog2(WINDOW_SIZE);
   localparam int SUM_W     = RISE_W + WIN_L;
   localparam int MULT_W    = SUM_W + 1;
   localparam int PROD_W    = SUM_W + MULT_W;
   localparam int DIV_SHIFT = SUM_W + WIN_L;
   // Reciprocal of the window size; exact for every sum below 2**SUM_W.
   localparam logic [MULT_W-1:0] DIV_MULT =
      MULT_W'((2 ** DIV_SHIFT + WINDOW_SIZE - 1) / WINDOW_SIZE);
   localparam logic [CH_W-1:0] LAST_CH = CH_W'(CHANNELS - 1);

   // Input register.
   logic                s1_valid_ff, s1_valid_in;
   logic                s1_kind_ff;
   logic [CAL_W-1:0]    s1_cal_ff;
   logic [RISE_W-1:0]   s1_rise_ff;

   // Output register.
   logic                rsp_valid_ff, rsp_valid_in;
   logic                rsp_event_ff;
   logic [CAL_W-1:0]    rsp_chan_ff;

   // Channel state.
   logic [RISE_W-1:0]   win_ff  [CHANNELS][WINDOW_SIZE];
   logic [RISE_W-1:0]   win_in  [CHANNELS][WINDOW_SIZE];
   logic [SUM_W-1:0]    sum_ff  [CHANNELS];
   logic [SUM_W-1:0]    sum_in  [CHANNELS];
   logic [RISE_W-1:0]   base_ff [CHANNELS];
   logic [RISE_W-1:0]   base_in [CHANNELS];
   logic [CHANNELS-1:0] pressed_ff, pressed_in;
   logic [CH_W-1:0]     ptr_ff, ptr_in;
   logic [THRESH_W-1:0] thresh_ff, thresh_in;

   logic                advance;
   logic                req_fire;
   logic                is_scan;
   logic                cal_ok;
   logic [CH_W-1:0]     ch;
   logic [RISE_W-1:0]   diff;
   logic [RISE_W:0]     mag;
   logic                over;
   logic                press;
   logic                push;
   logic [SUM_W-1:0]    sum_new;
   logic [PROD_W-1:0]   prod;
   logic [RISE_W-1:0]   base_new;
   logic [RISE_W-1:0]   oldest [CHANNELS];

   // A beat leaves the input register when the output register is free or
   // is being emptied in the same cycle.
   assign advance    = s1_valid_ff && (!rsp_valid_ff || rsp_tready);
   assign req_tready = !s1_valid_ff || advance;
   assign req_fire   = req_tvalid && req_tready;

   assign csr_ready  = 1'b1;
   assign thresh_in  = csr_valid ? csr_wdata : thresh_ff;

   assign rsp_tvalid = rsp_valid_ff;
   assign rsp_tuser  = rsp_event_ff;
   assign rsp_tdata  = RSP_DATA_W'(rsp_chan_ff);

   assign s1_valid_in  = req_fire ? 1'b1 : (advance ? 1'b0 : s1_valid_ff);
   assign rsp_valid_in = advance ? 1'b1 : (rsp_tready ? 1'b0 : rsp_valid_ff);

   for (genvar c = 0; c < CHANNELS; c++) begin : g_tap
      assign oldest[c] = win_ff[c][0];
   end

   always_comb begin
      is_scan  = (s1_kind_ff == KIND_SCAN);
      cal_ok   = (32'(s1_cal_ff) < 32'(CHANNELS));
      ch       = is_scan ? ptr_ff : CH_W'(s1_cal_ff);

      // Wrapped 16-bit difference, magnitude in 0..32768.
      diff     = s1_rise_ff - base_ff[ch];
      mag      = diff[RISE_W-1] ? ((RISE_W+1)'(1) << RISE_W) - {1'b0, diff}
                                : {1'b0, diff};
      over     = (mag > {1'b0, thresh_ff});
      press    = is_scan && over && !pressed_ff[ch];
      push     = is_scan ? !over : cal_ok;

      sum_new  = sum_ff[ch] - SUM_W'(oldest[ch]) + SUM_W'(s1_rise_ff);
      prod     = PROD_W'(sum_new) * PROD_W'(DIV_MULT);
      base_new = prod[DIV_SHIFT +: RISE_W];

      win_in     = win_ff;
      sum_in     = sum_ff;
      base_in    = base_ff;
      pressed_in = pressed_ff;
      ptr_in     = ptr_ff;

      if (advance) begin
         if (push) begin
            for (int i = 0; i < WINDOW_SIZE - 1; i++) begin
               win_in[ch][i] = win_ff[ch][i+1];
            end
            win_in[ch][WINDOW_SIZE-1] = s1_rise_ff;
            sum_in[ch]  = sum_new;
            base_in[ch] = base_new;
         end
         if (is_scan) begin
            if (press) begin
               pressed_in[ch] = 1'b1;
            end else if (!over) begin
               pressed_in[ch] = 1'b0;
            end
            // The pointer stays on a channel that has just been pressed.
            if (!press) begin
               ptr_in = (ptr_ff == LAST_CH) ? '0 : ptr_ff + CH_W'(1);
            end
         end
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         s1_valid_ff  <= 1'b0;
         rsp_valid_ff <= 1'b0;
         pressed_ff   <= '0;
         ptr_ff       <= '0;
         thresh_ff    <= THRESHOLD_RESET;
         for (int c = 0; c < CHANNELS; c++) begin
            sum_ff[c]  <= '0;
            base_ff[c] <= '0;
            for (int i = 0; i < WINDOW_SIZE; i++) begin
               win_ff[c][i] <= '0;
            end
         end
      end else begin
         s1_valid_ff  <= s1_valid_in;
         rsp_valid_ff <= rsp_valid_in;
         pressed_ff   <= pressed_in;
         ptr_ff       <= ptr_in;
         thresh_ff    <= thresh_in;
         sum_ff       <= sum_in;
         base_ff      <= base_in;
         win_ff       <= win_in;
      end
   end

   always_ff @(posedge clock) begin
      if (req_fire) begin
         s1_kind_ff <= req_tuser;
         s1_cal_ff  <= req_tdata[CAL_W-1:0];
         s1_rise_ff <= req_tdata[CAL_W +: RISE_W];
      end
      if (advance) begin
         rsp_event_ff <= press;
         rsp_chan_ff  <= CAL_W'(ptr_ff);
      end
   end

endmodule

@@ rtl/tsbd_checker.sv @@
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// Touch scan baseline detector checker
// Port-level checks on the detector, attached to every instance by bind.
// ----------------------------------------------------------------------------
module tsbd_checker #(
   parameter int CHANNELS = tsbd_pkg::CHANNELS_DEF
) (
   input logic                            clock,
   input logic                            reset,
   input logic                            req_tready,
   input logic                            rsp_tvalid,
   input logic                            rsp_tready,
   input logic [tsbd_pkg::RSP_DATA_W-1:0] rsp_tdata,
   input logic                            rsp_tuser
);

   import tsbd_pkg::*;

   // A stalled response beat keeps its contents.
   a_rsp_hold: assert property (@(posedge clock) disable iff (reset)
      rsp_tvalid && !rsp_tready |=> rsp_tvalid && $stable(rsp_tdata) && $stable(rsp_tuser))
      else $error("response beat changed while stalled");

   // No response is pending right after reset.
   a_rsp_reset: assert property (@(posedge clock)
      $past(reset) |-> !rsp_tvalid)
      else $error("response valid after reset");

   // With the response side empty the block always takes a new request.
   a_no_stall: assert property (@(posedge clock) disable iff (reset)
      $past(!reset) && !rsp_tvalid |-> req_tready)
      else $error("request stalled with empty response side");

   // The reported channel is always a real channel; the check is skipped above eight channels.
   a_chan_range: assert property (@(posedge clock) disable iff (reset)
      rsp_tvalid |-> (32'(rsp_tdata[CAL_W-1:0]) < 32'(CHANNELS)) || (CHANNELS > 8))
      else $error("reported channel out of range");

endmodule

bind touch_scan_baseline_detector tsbd_checker #(.CHANNELS(CHANNELS)) u_tsbd_checker (.*);
